// ===== hdl/gto_pkg.sv =====
package gto_pkg;

  localparam int unsigned CordicStepsDefault = 24;
  localparam int unsigned IdxW = 5;
  localparam int unsigned SqrtSteps = 31;
  localparam int unsigned XW = 36;
  localparam int unsigned MulW = 33;

  localparam logic [23:0] RadiusReset = 24'd6378137;
  localparam logic signed [MulW-1:0] RadPerDegK = 33'sd18740330;
  localparam logic signed [XW-1:0] CordicGainInv = 36'sd652032874;
  localparam logic signed [XW-1:0] OneQ30 = 36'sd1073741824;
  localparam logic signed [33:0] FullDeg = 34'sd6039797760;
  localparam logic signed [33:0] HalfDeg = 34'sd3019898880;
  localparam logic signed [33:0] QuarterDeg = 34'sd1509949440;
  localparam logic [32:0] SpeedMax = 33'h1_FFFF_FFFF;
  localparam logic [47:0] TotalMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] IndexMax = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
  } in_t;

  typedef struct packed {
    logic [31:0] sample_index;
    logic [47:0] total_distance;
    logic [32:0] step_speed;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ANGLE,
    OP_RAD,
    OP_ROT,
    OP_STORE,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_MUL4,
    OP_SQRT_A,
    OP_SQRT_STEP,
    OP_SQRT_B,
    OP_VEC_INIT,
    OP_VEC,
    OP_SEG_UPDATE
  } op_e;

  typedef struct packed {
    op_e            op;
    logic           update;
    logic [1:0]     sel;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] atan_q30(input logic [IdxW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd843314856;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043836;
      5'd3:  r = 32'd133525158;
      5'd4:  r = 32'd67021686;
      5'd5:  r = 32'd33543515;
      5'd6:  r = 32'd16775850;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194282;
      5'd9:  r = 32'd2097149;
      5'd10: r = 32'd1048575;
      5'd11: r = 32'd524287;
      5'd12: r = 32'd262143;
      5'd13: r = 32'd131071;
      5'd14: r = 32'd65535;
      5'd15: r = 32'd32767;
      5'd16: r = 32'd16383;
      5'd17: r = 32'd8191;
      5'd18: r = 32'd4095;
      5'd19: r = 32'd2047;
      5'd20: r = 32'd1023;
      5'd21: r = 32'd511;
      5'd22: r = 32'd255;
      5'd23: r = 32'd127;
      5'd24: r = 32'd63;
      5'd25: r = 32'd31;
      5'd26: r = 32'd15;
      5'd27: r = 32'd7;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/gto_ctrl.sv =====
module gto_ctrl #(
  parameter int unsigned CORDIC_STEPS = gto_pkg::CordicStepsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gto_pkg::sts_t sts_i,
  output gto_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ANGLE, S_RAD, S_ROT, S_STORE, S_MUL, S_SQRT_A, S_SQRT_STEP_A,
    S_SQRT_B, S_SQRT_STEP_B, S_VEC_INIT, S_VEC, S_FINISH
  } state_e;

  localparam logic [gto_pkg::IdxW-1:0] CordicLast = gto_pkg::IdxW'(CORDIC_STEPS - 1);
  localparam logic [gto_pkg::IdxW-1:0] SqrtLast = gto_pkg::IdxW'(gto_pkg::SqrtSteps - 1);

  state_e state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic [gto_pkg::IdxW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    sel_d = sel_q;
    cnt_d = cnt_q;
    cmd_o.op = gto_pkg::OP_NONE;
    cmd_o.update = 1'b0;
    cmd_o.sel = sel_q;
    cmd_o.idx = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = gto_pkg::OP_LOAD;
          sel_d = 2'd0;
          cnt_d = '0;
          state_d = sts_i.have_prev ? S_ANGLE : S_FINISH;
        end
      end
      S_ANGLE: begin
        cmd_o.op = gto_pkg::OP_ANGLE;
        state_d = S_RAD;
      end
      S_RAD: begin
        cmd_o.op = gto_pkg::OP_RAD;
        cnt_d = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        cmd_o.op = gto_pkg::OP_ROT;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CordicLast) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.op = gto_pkg::OP_STORE;
        cnt_d = '0;
        sel_d = sel_q + 1'b1;
        state_d = (sel_q == 2'd3) ? S_MUL : S_ANGLE;
      end
      S_MUL: begin
        case (cnt_q[1:0])
          2'd0: cmd_o.op = gto_pkg::OP_MUL1;
          2'd1: cmd_o.op = gto_pkg::OP_MUL2;
          2'd2: cmd_o.op = gto_pkg::OP_MUL3;
          default: cmd_o.op = gto_pkg::OP_MUL4;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = S_SQRT_A;
        end
      end
      S_SQRT_A: begin
        cmd_o.op = gto_pkg::OP_SQRT_A;
        cnt_d = '0;
        state_d = S_SQRT_STEP_A;
      end
      S_SQRT_STEP_A, S_SQRT_STEP_B: begin
        cmd_o.op = gto_pkg::OP_SQRT_STEP;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SqrtLast) begin
          state_d = (state_q == S_SQRT_STEP_A) ? S_SQRT_B : S_VEC_INIT;
        end
      end
      S_SQRT_B: begin
        cmd_o.op = gto_pkg::OP_SQRT_B;
        cnt_d = '0;
        state_d = S_SQRT_STEP_B;
      end
      S_VEC_INIT: begin
        cmd_o.op = gto_pkg::OP_VEC_INIT;
        cnt_d = '0;
        state_d = S_VEC;
      end
      S_VEC: begin
        cmd_o.op = gto_pkg::OP_VEC;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CordicLast) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.op = gto_pkg::OP_SEG_UPDATE;
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q <= 2'd0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/gto_datapath.sv =====
module gto_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gto_pkg::cmd_t  cmd_i,
  output gto_pkg::sts_t  sts_o,
  input  gto_pkg::in_t   in_data_i,
  input  logic           cfg_valid_i,
  input  logic [23:0]    cfg_data_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output gto_pkg::out_t  out_data_o
);

  localparam int unsigned XW = gto_pkg::XW;
  localparam int unsigned MW = gto_pkg::MulW;

  logic [23:0] radius_q;
  logic have_prev_q;
  logic signed [31:0] last_lat_q, last_lon_q;
  logic [47:0] total_q;
  logic [31:0] count_q;
  logic out_valid_q;
  gto_pkg::out_t out_q;

  logic signed [31:0] cur_lat_q, cur_lon_q;
  logic signed [31:0] deg_q, deg_d;
  logic neg_q, neg_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [31:0] s_lat_q, s_lon_q, c1_q, c2_q;
  logic signed [31:0] pa_q, pb_q, a_q, a_d;
  logic [61:0] rem_q, rem_d, root_q, root_d;

  logic signed [33:0] ang, ang_r;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] prod, prod_r;
  logic signed [XW-1:0] xs, ys, tz, xc, yc, sum_a;
  logic signed [31:0] sin_v, cos_v;
  logic [61:0] bitv, trial;
  logic [5:0] bsh;
  logic [30:0] one_minus;
  logic signed [MW-1:0] zc;
  logic [33:0] seg_raw;
  logic [32:0] seg, seg_use;
  logic [48:0] total_sum;
  logic [47:0] total_d;
  logic [31:0] count_d;

  always_comb begin
    case (cmd_i.sel)
      2'd0: ang = 34'(cur_lat_q) - 34'(last_lat_q);
      2'd1: ang = 34'(cur_lon_q) - 34'(last_lon_q);
      2'd2: ang = 34'(cur_lat_q) <<< 1;
      default: ang = 34'(last_lat_q) <<< 1;
    endcase
    if (ang >= gto_pkg::HalfDeg) begin
      ang_r = ang - gto_pkg::FullDeg;
    end else if (ang < -gto_pkg::HalfDeg) begin
      ang_r = ang + gto_pkg::FullDeg;
    end else begin
      ang_r = ang;
    end
    if (ang_r > gto_pkg::QuarterDeg) begin
      deg_d = 32'(ang_r - gto_pkg::HalfDeg);
      neg_d = 1'b1;
    end else if (ang_r < -gto_pkg::QuarterDeg) begin
      deg_d = 32'(ang_r + gto_pkg::HalfDeg);
      neg_d = 1'b1;
    end else begin
      deg_d = 32'(ang_r);
      neg_d = 1'b0;
    end
  end

  always_comb begin
    if (z_q < 0) begin
      zc = '0;
    end else if (z_q > (36'sd1 <<< 31)) begin
      zc = 33'sd1 <<< 31;
    end else begin
      zc = MW'(z_q);
    end
    case (cmd_i.op)
      gto_pkg::OP_RAD: begin
        mul_a = MW'(deg_q);
        mul_b = gto_pkg::RadPerDegK;
      end
      gto_pkg::OP_MUL1: begin
        mul_a = MW'(c1_q);
        mul_b = MW'(c2_q);
      end
      gto_pkg::OP_MUL2: begin
        mul_a = MW'(s_lon_q);
        mul_b = MW'(s_lon_q);
      end
      gto_pkg::OP_MUL3: begin
        mul_a = MW'(pa_q);
        mul_b = MW'(pb_q);
      end
      gto_pkg::OP_MUL4: begin
        mul_a = MW'(s_lat_q);
        mul_b = MW'(s_lat_q);
      end
      default: begin
        mul_a = zc;
        mul_b = $signed({9'b0, radius_q});
      end
    endcase
    prod = mul_a * mul_b;
    prod_r = prod >>> 30;
  end

  always_comb begin
    xs = x_q >>> cmd_i.idx;
    ys = y_q >>> cmd_i.idx;
    tz = $signed({4'b0, gto_pkg::atan_q30(cmd_i.idx)});
    if (x_q > gto_pkg::OneQ30) begin
      xc = gto_pkg::OneQ30;
    end else if (x_q < -gto_pkg::OneQ30) begin
      xc = -gto_pkg::OneQ30;
    end else begin
      xc = x_q;
    end
    if (y_q > gto_pkg::OneQ30) begin
      yc = gto_pkg::OneQ30;
    end else if (y_q < -gto_pkg::OneQ30) begin
      yc = -gto_pkg::OneQ30;
    end else begin
      yc = y_q;
    end
    sin_v = neg_q ? -32'(yc) : 32'(yc);
    cos_v = neg_q ? -32'(xc) : 32'(xc);
    sum_a = XW'(a_q) + XW'(prod_r);
    bsh = 6'd60 - {cmd_i.idx, 1'b0};
    bitv = 62'd1 << bsh;
    trial = root_q + bitv;
    one_minus = 31'h4000_0000 - a_q[30:0];
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    a_d = a_q;
    rem_d = rem_q;
    root_d = root_q;
    case (cmd_i.op)
      gto_pkg::OP_RAD: begin
        x_d = gto_pkg::CordicGainInv;
        y_d = '0;
        z_d = XW'((prod + (66'sd1 <<< 23)) >>> 24);
      end
      gto_pkg::OP_ROT: begin
        if (z_q >= 0) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - tz;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + tz;
        end
      end
      gto_pkg::OP_VEC: begin
        if (y_q >= 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + tz;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - tz;
        end
      end
      gto_pkg::OP_MUL3: a_d = 32'(prod_r);
      gto_pkg::OP_MUL4: begin
        if (sum_a < 0) begin
          a_d = '0;
        end else if (sum_a > gto_pkg::OneQ30) begin
          a_d = 32'(gto_pkg::OneQ30);
        end else begin
          a_d = 32'(sum_a);
        end
      end
      gto_pkg::OP_SQRT_A: begin
        rem_d = {1'b0, a_q[30:0], 30'b0};
        root_d = '0;
      end
      gto_pkg::OP_SQRT_STEP: begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          root_d = (root_q >> 1) + bitv;
        end else begin
          root_d = root_q >> 1;
        end
      end
      gto_pkg::OP_SQRT_B: begin
        y_d = XW'(root_q);
        rem_d = {1'b0, one_minus, 30'b0};
        root_d = '0;
      end
      gto_pkg::OP_VEC_INIT: begin
        x_d = XW'(root_q);
        z_d = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    seg_raw = 34'((prod + (66'sd1 <<< 20)) >>> 21);
    seg = (seg_raw > 34'(gto_pkg::SpeedMax)) ? gto_pkg::SpeedMax : seg_raw[32:0];
    seg_use = have_prev_q ? seg : '0;
    total_sum = {1'b0, total_q} + 49'(seg_use);
    if (!have_prev_q) begin
      total_d = '0;
      count_d = '0;
    end else begin
      total_d = total_sum[48] ? gto_pkg::TotalMax : total_sum[47:0];
      count_d = (count_q == gto_pkg::IndexMax) ? count_q : count_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == gto_pkg::OP_LOAD) begin
      cur_lat_q <= 32'(in_data_i.latitude);
      cur_lon_q <= in_data_i.longitude;
    end
    if (cmd_i.op == gto_pkg::OP_ANGLE) begin
      deg_q <= deg_d;
      neg_q <= neg_d;
    end
    if (cmd_i.op == gto_pkg::OP_STORE) begin
      case (cmd_i.sel)
        2'd0: s_lat_q <= sin_v;
        2'd1: s_lon_q <= sin_v;
        2'd2: c1_q <= cos_v;
        default: c2_q <= cos_v;
      endcase
    end
    if (cmd_i.op == gto_pkg::OP_MUL1) begin
      pa_q <= 32'(prod_r);
    end
    if (cmd_i.op == gto_pkg::OP_MUL2) begin
      pb_q <= 32'(prod_r);
    end
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    a_q <= a_d;
    rem_q <= rem_d;
    root_q <= root_d;
    if (cmd_i.update) begin
      out_q.sample_index <= count_d;
      out_q.total_distance <= total_d;
      out_q.step_speed <= seg_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gto_pkg::RadiusReset;
      have_prev_q <= 1'b0;
      last_lat_q <= '0;
      last_lon_q <= '0;
      total_q <= '0;
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        radius_q <= cfg_data_i;
      end
      if (cmd_i.update) begin
        have_prev_q <= 1'b1;
        last_lat_q <= cur_lat_q;
        last_lon_q <= cur_lon_q;
        total_q <= total_d;
        count_q <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.have_prev = have_prev_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ===== hdl/gps_track_odometer.sv =====
// Sequencing: the first fix after reset goes straight to the output register; every later
// fix runs four CORDIC rotations, two 31-step square roots and one CORDIC vectoring
// run on a shared unit.
// Flow: one fix at a time; the next fix is taken while the result waits.
// Reset: asynchronous, clears position, count and total; radius returns to 6378137 m.
module gps_track_odometer #(
  parameter int unsigned CORDIC_STEPS = gto_pkg::CordicStepsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gto_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gto_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [23:0]   cfg_data_i
);

  gto_pkg::cmd_t cmd;
  gto_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  gto_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gto_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while busy");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before taken");

  a_total_covers_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.total_distance >= {15'b0, out_data_o.step_speed}))
    else $error("total below segment");
`endif

endmodule
